>>> src/cgef_pkg.sv
// ============================================================================
// cgef_pkg: shared types and constants for the cross-gradient edge filter
// Transaction payloads, register indexes, operation codes and defaults.
// ============================================================================
package cgef_pkg;

    // Default sizing of the line stores and the frame height range
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Saturation limit of one edge sample
    localparam logic [8:0] SAT_MAX = 9'd255;

    // Configuration register widths and port shape
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_ENABLE = 2'd2;

    // Register values after reset
    localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic                    ALPHA_ENABLE_RST = 1'b0;

    // Operation codes of an input transaction
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Input transaction
    typedef struct packed {
        logic       operation;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic [7:0] alpha_out;
        logic       frame_end;
    } t_out;

    // Per-item control carried from the accept stage to the compute stage
    typedef struct packed {
        logic emit;       // item produces a result
        logic last;       // last pixel of the frame
        logic left_mid;   // left neighbor clamps to center
        logic right_mid;  // right neighbor clamps to center
        logic top_mid;    // top neighbor clamps to center
        logic bot_cur;    // bottom neighbor is the incoming pixel
    } t_ctl;

    // Lane results handed to the merge stage
    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic [7:0] alpha;
        logic       last;
    } t_lane_res;

endpackage

>>> src/cgef_lane.sv
// ============================================================================
// cgef_lane: edge strength of one color channel
// Max of horizontal and vertical absolute-difference sums, saturated.
// ============================================================================
module cgef_lane (
    input  logic [7:0] i_center,
    input  logic [7:0] i_left,
    input  logic [7:0] i_right,
    input  logic [7:0] i_top,
    input  logic [7:0] i_bottom,
    output logic [7:0] o_edge
);

    logic [7:0] d_left, d_right, d_top, d_bottom;
    logic [8:0] sum_h, sum_v, sum_max;

    // absolute differences to the four cross neighbors
    assign d_left   = (i_center > i_left)   ? i_center - i_left   : i_left   - i_center;
    assign d_right  = (i_center > i_right)  ? i_center - i_right  : i_right  - i_center;
    assign d_top    = (i_center > i_top)    ? i_center - i_top    : i_top    - i_center;
    assign d_bottom = (i_center > i_bottom) ? i_center - i_bottom : i_bottom - i_center;

    assign sum_h = {1'b0, d_left} + {1'b0, d_right};
    assign sum_v = {1'b0, d_top}  + {1'b0, d_bottom};

    // larger sum, clipped to one byte
    assign sum_max = (sum_h > sum_v) ? sum_h : sum_v;
    assign o_edge  = (sum_max > cgef_pkg::SAT_MAX) ? cgef_pkg::SAT_MAX[7:0] : sum_max[7:0];

endmodule

>>> src/cgef_line_store.sv
// ============================================================================
// cgef_line_store: the two row buffers of the filter window
// Newer row: one write, two registered reads. Older row: one write, one
// registered read with bypass of a write landing on the same edge.
// ============================================================================
module cgef_line_store #(
    parameter int DEPTH = cgef_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    // read side, one request per accepted transaction that is not dropped
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_rd_addr_next,
    // newer row write (incoming pixel)
    input  logic          i_new_we,
    input  logic [31:0]   i_new_data,
    // older row write (center pixel leaving the compute stage)
    input  logic          i_old_we,
    input  logic [AW-1:0] i_old_addr,
    input  logic [31:0]   i_old_data,
    output logic [31:0]   o_mid,
    output logic [31:0]   o_right,
    output logic [31:0]   o_top
);

    logic [31:0] r_newer [DEPTH];
    logic [31:0] r_older [DEPTH];

    logic [31:0] r_mid, r_right, r_top_mem, r_byp_data;
    logic        r_byp;

    // newer row: write at the read address is seen as the old contents
    always_ff @(posedge i_clk) begin
        if (i_new_we) begin
            r_newer[i_rd_addr] <= i_new_data;
        end
        if (i_rd_en) begin
            r_mid   <= r_newer[i_rd_addr];
            r_right <= r_newer[i_rd_addr_next];
        end
    end

    // older row
    always_ff @(posedge i_clk) begin
        if (i_old_we) begin
            r_older[i_old_addr] <= i_old_data;
        end
        if (i_rd_en) begin
            r_top_mem <= r_older[i_rd_addr];
        end
    end

    // bypass when the older-row write and the read hit the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp      <= i_old_we && (i_old_addr == i_rd_addr);
            r_byp_data <= i_old_data;
        end
    end

    assign o_mid   = r_mid;
    assign o_right = r_right;
    assign o_top   = r_byp ? r_byp_data : r_top_mem;

endmodule

>>> src/cgef_merge.sv
// ============================================================================
// cgef_merge: joins the lane results into one output transaction
// Applies the alpha enable and holds the result until it is taken.
// ============================================================================
module cgef_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  cgef_pkg::t_lane_res i_res,
    input  logic                i_alpha_en,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output cgef_pkg::t_out      o_data
);

    logic           r_valid;
    cgef_pkg::t_out r_data;

    assign o_ready = !r_valid || !i_stall;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_data.edge_red   <= i_res.edge_red;
            r_data.edge_green <= i_res.edge_green;
            r_data.edge_blue  <= i_res.edge_blue;
            r_data.alpha_out  <= i_alpha_en ? i_res.alpha : 8'd0;
            r_data.frame_end  <= i_res.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/cross_gradient_edge_filter_unit.sv
// A result passes the compute stage register and then the merge stage register before it appears.
// Throughput: one transaction per cycle unless o_stall is raised; the row buffers are used per taken transaction.
// A pixel at row r, column x yields the result for row r-1, column x.
// Reset (synchronous, active low) clears counters, pipeline valids, config registers and r_left;
// the stage payloads and row buffers are not cleared and hold whatever was last written.
// ============================================================================
// cross_gradient_edge_filter_unit: streaming 3x3 cross edge filter, RGBA
// Accept stage tracks raster position, compute stage runs three channel
// lanes on the window, merge stage forms the output transaction.
// ============================================================================
module cross_gradient_edge_filter_unit #(
    parameter int MAX_WIDTH  = cgef_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cgef_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  cgef_pkg::t_in                        i_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output cgef_pkg::t_out                       o_data,
    input  logic                                 i_cfg_we,
    input  logic [cgef_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [cgef_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = AW + 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [cgef_pkg::CFG_WIDTH_W-1:0]  r_frame_width;
    logic [cgef_pkg::CFG_HEIGHT_W-1:0] r_frame_height;
    logic                              r_alpha_en;

    // raster position
    logic [AW-1:0] r_col, r_drain;
    logic [RW-1:0] r_row;
    logic          r_draining;

    // compute stage
    logic           r_s1_valid;
    cgef_pkg::t_ctl r_s1_ctl;
    logic [AW-1:0]  r_s1_x;
    logic [31:0]    r_s1_cur;
    logic [31:0]    r_left;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic           acc, is_pixel, take, s1_adv, merge_ready;
    logic [AW-1:0]  x;
    logic           row_end, frame_end_hit;
    cgef_pkg::t_ctl n_ctl;

    logic [31:0] mid, right_mem, top_mem;
    logic [31:0] nb_left, nb_right, nb_top, nb_bot;
    cgef_pkg::t_lane_res lane_res;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= cgef_pkg::FRAME_WIDTH_RST;
            r_frame_height <= cgef_pkg::FRAME_HEIGHT_RST;
            r_alpha_en     <= cgef_pkg::ALPHA_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cgef_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[cgef_pkg::CFG_WIDTH_W-1:0];
                end
                cgef_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[cgef_pkg::CFG_HEIGHT_W-1:0];
                end
                cgef_pkg::CFG_ALPHA_ENABLE: begin
                    r_alpha_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size, clamped into the supported range
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
    end

    // handshake; a drain outside the drain phase is dropped
    assign s1_adv   = r_s1_valid && (!r_s1_ctl.emit || merge_ready);
    assign o_stall  = r_s1_valid && !s1_adv;
    assign acc      = i_valid && !o_stall;
    assign is_pixel = (i_data.operation == cgef_pkg::OP_PIXEL);
    assign take     = is_pixel || r_draining;

    // window position of this transaction
    assign x             = is_pixel ? r_col : r_drain;
    assign row_end       = (WW'(x) + WW'(1)) >= w_eff;
    assign frame_end_hit = (HW'(r_row) + HW'(1)) >= h_eff;

    always_comb begin
        n_ctl.left_mid  = (x == '0);
        n_ctl.right_mid = row_end;
        if (is_pixel) begin
            n_ctl.emit    = (r_row != '0);
            n_ctl.last    = 1'b0;
            n_ctl.top_mid = (r_row == RW'(1));
            n_ctl.bot_cur = 1'b1;
        end else begin
            n_ctl.emit    = 1'b1;
            n_ctl.last    = row_end;
            n_ctl.top_mid = (h_eff == HW'(1));
            n_ctl.bot_cur = 1'b0;
        end
    end

    // raster counters and drain phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_drain    <= '0;
            r_draining <= 1'b0;
        end else if (acc && is_pixel) begin
            r_drain    <= '0;
            r_draining <= 1'b0;
            if (row_end) begin
                r_col <= '0;
                if (frame_end_hit) begin
                    r_row      <= '0;
                    r_draining <= 1'b1;
                end else begin
                    r_row <= r_row + RW'(1);
                end
            end else begin
                r_col <= r_col + AW'(1);
            end
        end else if (acc && r_draining) begin
            if (row_end) begin
                r_drain    <= '0;
                r_draining <= 1'b0;
            end else begin
                r_drain <= r_drain + AW'(1);
            end
        end
    end

    // compute stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc && take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // compute stage payload
    always_ff @(posedge i_clk) begin
        if (acc && take) begin
            r_s1_ctl <= n_ctl;
            r_s1_x   <= x;
            r_s1_cur <= {i_data.alpha_in, i_data.blue_in, i_data.green_in, i_data.red_in};
        end
    end

    // left neighbor: center of the previous item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (s1_adv) begin
            r_left <= mid;
        end
    end

    cgef_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk          (i_clk),
        .i_rd_en        (acc && take),
        .i_rd_addr      (x),
        .i_rd_addr_next (x + AW'(1)),
        .i_new_we       (acc && is_pixel),
        .i_new_data     ({i_data.alpha_in, i_data.blue_in, i_data.green_in, i_data.red_in}),
        .i_old_we       (s1_adv),
        .i_old_addr     (r_s1_x),
        .i_old_data     (mid),
        .o_mid          (mid),
        .o_right        (right_mem),
        .o_top          (top_mem)
    );

    // neighbor selection with edge clamping
    assign nb_left  = r_s1_ctl.left_mid  ? mid : r_left;
    assign nb_right = r_s1_ctl.right_mid ? mid : right_mem;
    assign nb_top   = r_s1_ctl.top_mid   ? mid : top_mem;
    assign nb_bot   = r_s1_ctl.bot_cur   ? r_s1_cur : mid;

    // one lane per color channel
    cgef_lane u_lane_red (
        .i_center (mid[7:0]),
        .i_left   (nb_left[7:0]),
        .i_right  (nb_right[7:0]),
        .i_top    (nb_top[7:0]),
        .i_bottom (nb_bot[7:0]),
        .o_edge   (lane_res.edge_red)
    );

    cgef_lane u_lane_green (
        .i_center (mid[15:8]),
        .i_left   (nb_left[15:8]),
        .i_right  (nb_right[15:8]),
        .i_top    (nb_top[15:8]),
        .i_bottom (nb_bot[15:8]),
        .o_edge   (lane_res.edge_green)
    );

    cgef_lane u_lane_blue (
        .i_center (mid[23:16]),
        .i_left   (nb_left[23:16]),
        .i_right  (nb_right[23:16]),
        .i_top    (nb_top[23:16]),
        .i_bottom (nb_bot[23:16]),
        .o_edge   (lane_res.edge_blue)
    );

    assign lane_res.alpha = mid[31:24];
    assign lane_res.last  = r_s1_ctl.last;

    cgef_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_adv && r_s1_ctl.emit),
        .i_res      (lane_res),
        .i_alpha_en (r_alpha_en),
        .i_stall    (i_stall),
        .o_ready    (merge_ready),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

    // stall is raised only while the compute stage holds a blocked item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s1_ctl.emit && o_valid))
        else $error("input stalled without a blocked result");

    // raster position stays at the top-left position throughout the drain phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_col == '0 && r_row == '0))
        else $error("raster position not reset while draining");

    // drain position stays at zero outside the drain phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_draining |-> (r_drain == '0))
        else $error("drain position moved outside the drain phase");

    // a result leaving the compute stage is presented next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_ctl.emit) |=> o_valid)
        else $error("result lost between compute and output stage");

    // a dropped drain does not move the raster position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !is_pixel && !r_draining) |=> ($stable(r_col) && $stable(r_row)
            && !r_draining))
        else $error("dropped drain changed the raster position");

endmodule
